FILE: src/wtc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wtc_pkg
// shared widths, action codes and controller/datapath handshake types
// ----------------------------------------------------------------------------
package wtc_pkg;

	localparam int ACTION_W = 2;
	localparam int KIND_W   = 2;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 9;
	localparam int CAP_W    = 10;
	localparam int METER_W  = 31;
	localparam int ENTRY_W  = KIND_W + VALUE_W;

	typedef logic [ACTION_W-1:0] action_t;

	localparam action_t ACT_RECORD = 2'd0;
	localparam action_t ACT_READ   = 2'd1;
	localparam action_t ACT_CLEAR  = 2'd2;
	localparam action_t ACT_COUNT  = 2'd3;

	localparam logic REPORT_READ  = 1'b0;
	localparam logic REPORT_COUNT = 1'b1;

	localparam logic [CAP_W-1:0]   CAP_RESET = 10'd512;
	localparam logic [METER_W-1:0] METER_MAX = {METER_W{1'b1}};

	typedef struct packed {
		logic record;
		logic clear;
		logic read_issue;
		logic count_issue;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

FILE: src/wtc_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wtc_ifs
// valid/ready channels for request words and result words
// ----------------------------------------------------------------------------
interface wtc_in_if;
	import wtc_pkg::*;

	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [KIND_W-1:0]   kind;
	logic [VALUE_W-1:0]  value;
	logic [POS_W-1:0]    position;
	logic                keep_count;

	modport source (output valid, action, kind, value, position, keep_count, input ready);
	modport sink   (input valid, action, kind, value, position, keep_count, output ready);
endinterface

interface wtc_out_if;
	import wtc_pkg::*;

	logic               valid;
	logic               ready;
	logic               report_type;
	logic               present;
	logic [KIND_W-1:0]  item_kind;
	logic [VALUE_W-1:0] item_value;
	logic [METER_W-1:0] arrivals;

	modport source (output valid, report_type, present, item_kind, item_value, arrivals,
		input ready);
	modport sink   (input valid, report_type, present, item_kind, item_value, arrivals,
		output ready);
endinterface
`default_nettype wire

FILE: src/wtc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wtc_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module wtc_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: src/wtc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wtc_ctrl
// sequencer: takes one request word, steps through read and result handoff
// ----------------------------------------------------------------------------
module wtc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire wtc_pkg::action_t  in_action,
	output      logic              in_ready,
	input  wire wtc_pkg::status_t  status,
	output      wtc_pkg::cmd_t     cmd
);
	import wtc_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (in_action)
						ACT_RECORD: cmd.record = 1'b1;
						ACT_CLEAR:  cmd.clear  = 1'b1;
						ACT_READ: begin
							cmd.read_issue = 1'b1;
							state_d        = ST_READ;
						end
						ACT_COUNT: begin
							cmd.count_issue = 1'b1;
							state_d         = ST_HOLD;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_READ: state_d = ST_HOLD;
			ST_HOLD: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

FILE: src/wtc_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wtc_dp
// ring pointers, arrival meter, entry store and result word register
// ----------------------------------------------------------------------------
module wtc_dp #(
	parameter int STORE_DEPTH = 512
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [wtc_pkg::CAP_W-1:0] cfg_wdata,
	input  wire logic [wtc_pkg::KIND_W-1:0]  kind,
	input  wire logic [wtc_pkg::VALUE_W-1:0] value,
	input  wire logic [wtc_pkg::POS_W-1:0]   position,
	input  wire logic                        keep_count,
	input  wire wtc_pkg::cmd_t             cmd,
	output      wtc_pkg::status_t          status,
	wtc_out_if.source                      rsp
);
	import wtc_pkg::*;

	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
	localparam int SUM_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
	localparam int EC_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	localparam logic [SUM_W-1:0]  DEPTH_S = SUM_W'(STORE_DEPTH);
	localparam logic [EC_W-1:0]   DEPTH_E = EC_W'(STORE_DEPTH);
	localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(STORE_DEPTH - 1);

	logic [CAP_W-1:0]   cap_q;
	logic [ADDR_W-1:0]  oldest_q;
	logic [CNT_W-1:0]   held_q;
	logic [METER_W-1:0] meter_q;
	logic               p_type_q;
	logic               p_present_q;
	logic               p_keep_q;
	logic               out_valid_q;
	logic               out_type_q;
	logic               out_present_q;
	logic [KIND_W-1:0]  out_kind_q;
	logic [VALUE_W-1:0] out_value_q;
	logic [METER_W-1:0] out_arrivals_q;

	logic [EC_W-1:0]    cap_e;
	logic [EC_W-1:0]    eff_cap;
	logic               full;
	logic [SUM_W-1:0]   wsum;
	logic [SUM_W-1:0]   rsum;
	logic [ADDR_W-1:0]  waddr;
	logic [ADDR_W-1:0]  raddr;
	logic               in_range;
	logic [ENTRY_W-1:0] rdata;

	// effective capacity, clamped to one..depth
	always_comb begin
		cap_e = EC_W'(cap_q);
		if (cap_e == '0) begin
			eff_cap = EC_W'(1);
		end else if (cap_e > DEPTH_E) begin
			eff_cap = DEPTH_E;
		end else begin
			eff_cap = cap_e;
		end
	end

	assign full = (EC_W'(held_q) >= eff_cap);

	// slot wrap, sums stay below twice the depth
	assign wsum  = SUM_W'(oldest_q) + SUM_W'(held_q);
	assign rsum  = SUM_W'(oldest_q) + SUM_W'(position);
	assign waddr = (wsum >= DEPTH_S) ? ADDR_W'(wsum - DEPTH_S) : ADDR_W'(wsum);
	assign raddr = (rsum >= DEPTH_S) ? ADDR_W'(rsum - DEPTH_S) : ADDR_W'(rsum);

	assign in_range = (SUM_W'(position) < SUM_W'(held_q));

	wtc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (STORE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.record),
		.waddr (waddr),
		.wdata ({kind, value}),
		.re    (cmd.read_issue),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign status.out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= CAP_RESET;
			oldest_q <= '0;
			held_q   <= '0;
			meter_q  <= '0;
		end else if (cfg_we) begin
			cap_q    <= cfg_wdata;
			oldest_q <= '0;
			held_q   <= '0;
			meter_q  <= '0;
		end else if (cmd.record) begin
			if (full) begin
				oldest_q <= (oldest_q == LAST_SLOT) ? '0 : oldest_q + ADDR_W'(1);
			end else begin
				held_q <= held_q + CNT_W'(1);
			end
			if (meter_q != METER_MAX) begin
				meter_q <= meter_q + METER_W'(1);
			end
		end else if (cmd.clear) begin
			oldest_q <= '0;
			held_q   <= '0;
		end else if (cmd.load_out && p_type_q == REPORT_COUNT && !p_keep_q) begin
			meter_q <= '0;
		end
	end

	// pending result description
	always_ff @(posedge clk) begin
		if (cmd.read_issue || cmd.count_issue) begin
			p_type_q    <= cmd.count_issue ? REPORT_COUNT : REPORT_READ;
			p_present_q <= in_range && cmd.read_issue;
			p_keep_q    <= keep_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_type_q    <= p_type_q;
			out_present_q <= p_present_q;
			if (p_present_q) begin
				out_kind_q  <= rdata[ENTRY_W-1:VALUE_W];
				out_value_q <= rdata[VALUE_W-1:0];
			end else begin
				out_kind_q  <= '0;
				out_value_q <= '0;
			end
			out_arrivals_q <= (p_type_q == REPORT_COUNT) ? meter_q : '0;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.report_type = out_type_q;
	assign rsp.present     = out_present_q;
	assign rsp.item_kind   = out_kind_q;
	assign rsp.item_value  = out_value_q;
	assign rsp.arrivals    = out_arrivals_q;

endmodule
`default_nettype wire

FILE: src/wrapping_trace_capture_buffer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wrapping_trace_capture_buffer_unit
// trace capture ring that overwrites its oldest entry when full
// ----------------------------------------------------------------------------
// A record or clear word is taken in the idle state, so records stream in one
// per clock unless a read or count is in flight. A read word passes the idle,
// read and hold states, a count word idle and hold: the store has a registered
// read port, and the result word goes through an output register that frees up
// as soon as the sink takes it; a stalled sink keeps the word in the hold
// state. The store is not cleared after reset and is ready at once; entries
// never written are never reported as present. Writing capacity empties the
// ring and zeroes the arrival meter; write it only while no word is in flight.
module wrapping_trace_capture_buffer_unit #(
	parameter int STORE_DEPTH = 512
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [wtc_pkg::CAP_W-1:0] cfg_wdata,
	wtc_in_if.sink                         req,
	wtc_out_if.source                      rsp
);
	import wtc_pkg::*;

	cmd_t    cmd;
	status_t status;

	wtc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_action (req.action),
		.in_ready  (req.ready),
		.status    (status),
		.cmd       (cmd)
	);

	wtc_dp #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.kind       (req.kind),
		.value      (req.value),
		.position   (req.position),
		.keep_count (req.keep_count),
		.cmd        (cmd),
		.status     (status),
		.rsp        (rsp)
	);

	a_load_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> status.out_free)
		else $error("result word loaded over an untaken one");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.record, cmd.clear, cmd.read_issue, cmd.count_issue, cmd.load_out}))
		else $error("more than one datapath command at once");

	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.read_issue |=> !req.ready ##1 !req.ready)
		else $error("request taken while a read is in flight");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> rsp.valid)
		else $error("loaded result word not offered");

endmodule
`default_nettype wire

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// checks the wrapping trace capture ring against a cycle-free predictor
// ----------------------------------------------------------------------------
// A short table of directed words covers the empty ring, extreme payloads,
// the undefined kind, reads past the held items, clear and both count modes.
// Random words then run under several capacity settings (zero, one, full and
// beyond). Records dominate so that the ring fills and wraps. The sender works
// in bursts, and the receiver stalls on its own pattern with one long hold-off.
// Every result word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import wtc_pkg::*;

	localparam int DEPTH          = 512;
	localparam int CYCLE_LIMIT    = 500000;
	localparam int HOLDOFF_CYCLES = 300;

	localparam logic [KIND_W-1:0] KIND_INT    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FLOAT  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SYMBOL = 2'd2;
	localparam logic [KIND_W-1:0] KIND_UNDEF  = 2'd3;

	typedef struct packed {
		action_t             action;
		logic [KIND_W-1:0]   kind;
		logic [VALUE_W-1:0]  value;
		logic [POS_W-1:0]    position;
		logic                keep_count;
	} trace_req_t;

	typedef struct packed {
		logic                report_type;
		logic                present;
		logic [KIND_W-1:0]   item_kind;
		logic [VALUE_W-1:0]  item_value;
		logic [METER_W-1:0]  arrivals;
	} trace_rsp_t;

	typedef struct {
		trace_req_t req;
		bit         fixed;
		trace_rsp_t rsp;
	} script_row_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_wdata;

	wtc_in_if  req_if ();
	wtc_out_if rsp_if ();

	wrapping_trace_capture_buffer_unit #(.STORE_DEPTH(DEPTH)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req_if),
		.rsp      (rsp_if)
	);

	always #5 clk = ~clk;

	// predicted ring state
	logic [ENTRY_W-1:0] ring_mem [DEPTH];
	int unsigned        ring_oldest;
	int unsigned        ring_held;
	logic [CAP_W-1:0]   ring_cap;
	logic [METER_W-1:0] arrival_meter;

	trace_rsp_t  pending_reports [$];
	int          mismatches  = 0;
	int          burst_left  = 0;
	bit          holdoff_req = 1'b0;
	int unsigned cycle_count = 0;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	function automatic bit ring_step(input trace_req_t w, output trace_rsp_t r);
		int unsigned lim;
		bit          has;
		r   = '0;
		has = 1'b0;
		lim = (ring_cap == 0) ? 1 : (ring_cap > DEPTH) ? DEPTH : ring_cap;
		case (w.action)
			ACT_RECORD: begin
				ring_mem[(ring_oldest + ring_held) % DEPTH] = {w.kind, w.value};
				if (ring_held < lim)
					ring_held++;
				else
					ring_oldest = (ring_oldest + 1) % DEPTH;
				if (arrival_meter != METER_MAX)
					arrival_meter++;
			end
			ACT_READ: begin
				has = 1'b1;
				r.report_type = REPORT_READ;
				if (w.position < ring_held) begin
					r.present = 1'b1;
					{r.item_kind, r.item_value} = ring_mem[(ring_oldest + w.position) % DEPTH];
				end
			end
			ACT_CLEAR: begin
				ring_oldest = 0;
				ring_held   = 0;
			end
			default: begin
				has = 1'b1;
				r.report_type = REPORT_COUNT;
				r.arrivals    = arrival_meter;
				if (!w.keep_count)
					arrival_meter = '0;
			end
		endcase
		return has;
	endfunction

	function automatic script_row_t row(action_t a, logic [KIND_W-1:0] k,
		logic [VALUE_W-1:0] v, logic [POS_W-1:0] p, logic kc, bit fx, logic pr,
		logic [KIND_W-1:0] ik, logic [VALUE_W-1:0] iv, logic [METER_W-1:0] arr);
		script_row_t s;
		s.req   = {a, k, v, p, kc};
		s.fixed = fx;
		s.rsp   = {(a == ACT_COUNT) ? REPORT_COUNT : REPORT_READ, pr, ik, iv, arr};
		return s;
	endfunction

	function automatic trace_req_t make_word(int rec_pct, int clr_pct);
		trace_req_t w;
		int         r;
		r = $urandom_range(99);
		if (r < rec_pct)
			w.action = ACT_RECORD;
		else if (r < rec_pct + clr_pct)
			w.action = ACT_CLEAR;
		else if ($urandom_range(3) == 0)
			w.action = ACT_COUNT;
		else
			w.action = ACT_READ;
		w.kind  = ($urandom_range(9) == 0) ? KIND_UNDEF : KIND_W'($urandom_range(KIND_SYMBOL));
		w.value = $urandom;
		if (ring_held != 0 && $urandom_range(4) != 0)
			w.position = POS_W'($urandom_range(ring_held - 1));
		else
			w.position = POS_W'($urandom_range(DEPTH - 1));
		w.keep_count = 1'($urandom_range(1));
		return w;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (mismatches < 40)
			$display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
		mismatches++;
	endtask

	task automatic send_word(input trace_req_t w, input bit fixed, input trace_rsp_t typed);
		trace_rsp_t pred;
		req_if.valid      <= 1'b1;
		req_if.action     <= w.action;
		req_if.kind       <= w.kind;
		req_if.value      <= w.value;
		req_if.position   <= w.position;
		req_if.keep_count <= w.keep_count;
		do @(posedge clk); while (!req_if.ready);
		if (ring_step(w, pred))
			pending_reports.push_back(fixed ? typed : pred);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(8, 1)) @(posedge clk);
			burst_left = ($urandom_range(5) == 0) ? $urandom_range(200, 60) : $urandom_range(24);
		end
	endtask

	// let the ring go quiet, including records still in flight
	task automatic drain();
		req_if.valid <= 1'b0;
		wait (pending_reports.size() == 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		cfg_we    <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we        <= 1'b0;
		ring_cap      = cap;
		ring_oldest   = 0;
		ring_held     = 0;
		arrival_meter = '0;
	endtask

	// result side: checking and stall pattern
	initial begin
		int         run_left;
		int         stall_pct;
		int         hold_left;
		trace_rsp_t got;
		trace_rsp_t want;
		run_left     = 0;
		stall_pct    = 0;
		hold_left    = 0;
		rsp_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_if.valid && rsp_if.ready) begin
				got = {rsp_if.report_type, rsp_if.present, rsp_if.item_kind,
					rsp_if.item_value, rsp_if.arrivals};
				if (pending_reports.size() == 0) begin
					report_mismatch("unexpected word", got.item_value, '0);
				end else begin
					want = pending_reports.pop_front();
					if (got.report_type !== want.report_type)
						report_mismatch("report_type", got.report_type, want.report_type);
					if (got.present !== want.present)
						report_mismatch("present", got.present, want.present);
					if (got.item_kind !== want.item_kind)
						report_mismatch("item_kind", got.item_kind, want.item_kind);
					if (got.item_value !== want.item_value)
						report_mismatch("item_value", got.item_value, want.item_value);
					if (got.arrivals !== want.arrivals)
						report_mismatch("arrivals", got.arrivals, want.arrivals);
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else if (holdoff_req) begin
				holdoff_req  = 1'b0;
				hold_left    = HOLDOFF_CYCLES;
				rsp_if.ready <= 1'b0;
			end else begin
				if (run_left == 0) begin
					run_left = $urandom_range(150, 20);
					case ($urandom_range(4))
						0, 1: stall_pct = 0;
						2: stall_pct = 25;
						3: stall_pct = 60;
						default: stall_pct = 90;
					endcase
				end
				run_left--;
				rsp_if.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// request side
	initial begin
		script_row_t script [21];
		int unsigned ph_cap   [7] = '{0, 1, 2, 1023, 512, 7, 300};
		int          ph_items [7] = '{60, 60, 70, 620, 200, 120, 120};
		int          ph_rec   [7] = '{60, 60, 60, 90, 50, 60, 70};
		int          ph_clr   [7] = '{4, 4, 4, 0, 4, 3, 3};

		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = '0;
		req_if.valid      = 1'b0;
		req_if.action     = ACT_RECORD;
		req_if.kind       = KIND_INT;
		req_if.value      = '0;
		req_if.position   = '0;
		req_if.keep_count = 1'b0;

		ring_cap      = CAP_RESET;
		ring_oldest   = 0;
		ring_held     = 0;
		arrival_meter = '0;

		script = '{
			row(ACT_READ,   KIND_INT,    32'h0,        9'd0,   1'b0, 1, 0, KIND_INT,    32'h0, 31'd0),
			row(ACT_COUNT,  KIND_INT,    32'h0,        9'd0,   1'b1, 1, 0, KIND_INT,    32'h0, 31'd0),
			row(ACT_RECORD, KIND_INT,    32'h0,        9'd0,   1'b0, 0, 0, KIND_INT,    32'h0, 31'd0),
			row(ACT_RECORD, KIND_UNDEF,  32'hffffffff, 9'd511, 1'b1, 0, 0, KIND_INT,    32'h0, 31'd0),
			row(ACT_READ,   KIND_INT,    32'h0,        9'd0,   1'b0, 1, 1, KIND_INT,    32'h0, 31'd0),
			row(ACT_READ,   KIND_INT,    32'h0,        9'd1,   1'b0, 1, 1, KIND_UNDEF,
				32'hffffffff, 31'd0),
			row(ACT_READ,   KIND_INT,    32'h0,        9'd2,   1'b0, 1, 0, KIND_INT,    32'h0, 31'd0),
			row(ACT_READ,   KIND_UNDEF,  32'hffffffff, 9'd511, 1'b1, 1, 0, KIND_INT,    32'h0, 31'd0),
			row(ACT_COUNT,  KIND_INT,    32'h0,        9'd0,   1'b1, 1, 0, KIND_INT,    32'h0, 31'd2),
			row(ACT_COUNT,  KIND_INT,    32'h0,        9'd0,   1'b0, 1, 0, KIND_INT,    32'h0, 31'd2),
			row(ACT_COUNT,  KIND_INT,    32'h0,        9'd0,   1'b0, 1, 0, KIND_INT,    32'h0, 31'd0),
			row(ACT_RECORD, KIND_FLOAT,  32'h3f800000, 9'd0,   1'b0, 0, 0, KIND_INT,    32'h0, 31'd0),
			row(ACT_RECORD, KIND_SYMBOL, 32'h80000001, 9'd0,   1'b0, 0, 0, KIND_INT,    32'h0, 31'd0),
			row(ACT_CLEAR,  KIND_UNDEF,  32'hffffffff, 9'd511, 1'b1, 0, 0, KIND_INT,    32'h0, 31'd0),
			row(ACT_READ,   KIND_INT,    32'h0,        9'd0,   1'b0, 1, 0, KIND_INT,    32'h0, 31'd0),
			row(ACT_COUNT,  KIND_INT,    32'h0,        9'd0,   1'b1, 1, 0, KIND_INT,    32'h0, 31'd2),
			row(ACT_RECORD, KIND_SYMBOL, 32'h1,        9'd0,   1'b0, 0, 0, KIND_INT,    32'h0, 31'd0),
			row(ACT_READ,   KIND_INT,    32'h0,        9'd0,   1'b0, 1, 1, KIND_SYMBOL, 32'h1, 31'd0),
			row(ACT_RECORD, KIND_FLOAT,  32'haaaa5555, 9'd0,   1'b0, 0, 0, KIND_INT,    32'h0, 31'd0),
			row(ACT_READ,   KIND_INT,    32'h0,        9'd1,   1'b0, 0, 0, KIND_INT,    32'h0, 31'd0),
			row(ACT_COUNT,  KIND_INT,    32'h0,        9'd0,   1'b0, 0, 0, KIND_INT,    32'h0, 31'd0)
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (script[i])
			send_word(script[i].req, script[i].fixed, script[i].rsp);
		for (int n = 0; n < 80; n++)
			send_word(make_word(55, 4), 1'b0, '0);

		for (int p = 0; p < 7; p++) begin
			drain();
			write_capacity(CAP_W'(ph_cap[p]));
			for (int n = 0; n < ph_items[p]; n++) begin
				if (p == 4 && n == 40)
					holdoff_req = 1'b1;
				if (p == 5 && n == 60)
					drain();
				send_word(make_word(ph_rec[p], ph_clr[p]), 1'b0, '0);
			end
		end

		drain();
		repeat (12) @(posedge clk);
		if (mismatches == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
